[rtl/core/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

    localparam int HP_W  = 16;
    localparam int TO_W  = 10;
    localparam int CFG_ADDR_W = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_PERIOD = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACK_TIMEOUT = 4'd1;

    localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd4;
    localparam logic [TO_W-1:0] ACK_TIMEOUT_RST = 10'd250;

    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STOP  = 3'd1;
    localparam logic [2:0] MODE_SEND  = 3'd2;
    localparam logic [2:0] MODE_WAIT  = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_WAIT  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef enum logic [15:0] {
        PH_IDLE    = 16'h0001,
        PH_ST_A    = 16'h0002,
        PH_ST_B    = 16'h0004,
        PH_SP_A    = 16'h0008,
        PH_SP_B    = 16'h0010,
        PH_SP_C    = 16'h0020,
        PH_TX_LO   = 16'h0040,
        PH_TX_HI   = 16'h0080,
        PH_TX_TAIL = 16'h0100,
        PH_WA_REL  = 16'h0200,
        PH_WA_HI   = 16'h0400,
        PH_WA_POLL = 16'h0800,
        PH_RD_LO   = 16'h1000,
        PH_RD_HI   = 16'h2000,
        PH_AK_LO   = 16'h4000,
        PH_AK_HI   = 16'h8000
    } phase_t;

endpackage

`default_nettype wire

[rtl/core/i2cm_front.sv]
`default_nettype none

// Input queue: decode each word into a command kind and hold up to two.
module i2cm_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [15:0]            s_tdata,   // cmd_valid, mode[2:0], tx_byte[7:0], send_ack, sda_in
    output logic                  q_valid,
    output i2cm_pkg::item_t       q_item,
    input  wire                   q_pop
);

    i2cm_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    i2cm_pkg::item_t in_item;
    logic            push;
    logic            pop;
    logic [2:0]      mode;

    assign mode = s_tdata[3:1];

    always_comb
    begin
        in_item.tx_byte  = s_tdata[11:4];
        in_item.send_ack = s_tdata[12];
        in_item.sda_in   = s_tdata[13];
        in_item.cmd      = i2cm_pkg::CMD_NONE;
        if (s_tdata[0])
        begin
            unique case (mode)
                i2cm_pkg::MODE_START: in_item.cmd = i2cm_pkg::CMD_START;
                i2cm_pkg::MODE_STOP:  in_item.cmd = i2cm_pkg::CMD_STOP;
                i2cm_pkg::MODE_SEND:  in_item.cmd = i2cm_pkg::CMD_SEND;
                i2cm_pkg::MODE_WAIT:  in_item.cmd = i2cm_pkg::CMD_WAIT;
                i2cm_pkg::MODE_READ:  in_item.cmd = i2cm_pkg::CMD_READ;
                default:              in_item.cmd = i2cm_pkg::CMD_NONE;
            endcase
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q_item = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/core/i2cm_back.sv]
`default_nettype none

// Bus sequencer: one queued word advances the bus state by one tick.
module i2cm_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire [3:0]             cfg_addr,
    input  wire [15:0]            cfg_wdata,
    input  wire                   q_valid,
    input  i2cm_pkg::item_t       q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [15:0]           m_tdata
);

    logic [15:0]       hp_reg;
    logic [9:0]        to_reg;

    i2cm_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]       dc_reg, dc_next;
    logic [3:0]        bc_reg, bc_next;
    logic [7:0]        sh_reg, sh_next;
    logic [9:0]        pc_reg, pc_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              fail_reg, fail_next;
    logic              ackl_reg, ackl_next;
    logic [7:0]        rx_reg, rx_next;
    logic              done;

    logic              out_valid_reg;
    logic [15:0]       out_data_reg;
    logic              step;
    logic [15:0]       hp_eff;
    logic [15:0]       dc_dec;
    logic [3:0]        bc_inc;

    assign step     = q_valid && (!out_valid_reg || m_tready);
    assign q_pop    = step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign hp_eff = (hp_reg == 16'd0) ? 16'd1 : hp_reg;
    assign dc_dec = (dc_reg != 16'd0) ? (dc_reg - 16'd1) : dc_reg;
    assign bc_inc = bc_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg <= i2cm_pkg::HALF_PERIOD_RST;
            to_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == i2cm_pkg::CFG_HALF_PERIOD)
            begin
                hp_reg <= cfg_wdata;
            end
            else if (cfg_addr == i2cm_pkg::CFG_ACK_TIMEOUT)
            begin
                to_reg <= cfg_wdata[9:0];
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        dc_next    = dc_reg;
        bc_next    = bc_reg;
        sh_next    = sh_reg;
        pc_next    = pc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        fail_next  = fail_reg;
        ackl_next  = ackl_reg;
        rx_next    = rx_reg;
        done       = 1'b0;

        if (phase_reg == i2cm_pkg::PH_IDLE)
        begin
            unique case (q_item.cmd)
                i2cm_pkg::CMD_START:
                begin
                    sda_next = 1'b1; scl_next = 1'b1;
                    phase_next = i2cm_pkg::PH_ST_A; dc_next = hp_eff;
                end
                i2cm_pkg::CMD_STOP:
                begin
                    scl_next = 1'b0; sda_next = 1'b0;
                    phase_next = i2cm_pkg::PH_SP_A; dc_next = hp_eff;
                end
                i2cm_pkg::CMD_SEND:
                begin
                    scl_next = 1'b0; bc_next = 4'd0;
                    sda_next = q_item.tx_byte[7];
                    sh_next  = {q_item.tx_byte[6:0], 1'b0};
                    phase_next = i2cm_pkg::PH_TX_LO; dc_next = hp_eff;
                end
                i2cm_pkg::CMD_WAIT:
                begin
                    sda_next = 1'b1; fail_next = 1'b0; pc_next = 10'd0;
                    phase_next = i2cm_pkg::PH_WA_REL; dc_next = hp_eff;
                end
                i2cm_pkg::CMD_READ:
                begin
                    sda_next = 1'b1; scl_next = 1'b0; sh_next = 8'd0; bc_next = 4'd0;
                    ackl_next = q_item.send_ack;
                    phase_next = i2cm_pkg::PH_RD_LO; dc_next = hp_eff;
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg == i2cm_pkg::PH_WA_POLL)
        begin
            priority if (!q_item.sda_in)
            begin
                scl_next = 1'b0; phase_next = i2cm_pkg::PH_IDLE; done = 1'b1;
            end
            else if (pc_reg >= to_reg)
            begin
                fail_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                phase_next = i2cm_pkg::PH_SP_A; dc_next = hp_eff;
            end
            else
            begin
                pc_next = pc_reg + 10'd1;
            end
        end
        else
        begin
            dc_next = dc_dec;
            if (dc_dec == 16'd0)
            begin
                unique case (phase_reg)
                    i2cm_pkg::PH_ST_A:
                    begin
                        sda_next = 1'b0; phase_next = i2cm_pkg::PH_ST_B; dc_next = hp_eff;
                    end
                    i2cm_pkg::PH_ST_B:
                    begin
                        scl_next = 1'b0; phase_next = i2cm_pkg::PH_IDLE; done = 1'b1;
                    end
                    i2cm_pkg::PH_SP_A:
                    begin
                        scl_next = 1'b1; phase_next = i2cm_pkg::PH_SP_B; dc_next = hp_eff;
                    end
                    i2cm_pkg::PH_SP_B:
                    begin
                        sda_next = 1'b1; phase_next = i2cm_pkg::PH_SP_C; dc_next = hp_eff;
                    end
                    i2cm_pkg::PH_SP_C:
                    begin
                        phase_next = i2cm_pkg::PH_IDLE; done = 1'b1;
                    end
                    i2cm_pkg::PH_TX_LO:
                    begin
                        scl_next = 1'b1; phase_next = i2cm_pkg::PH_TX_HI; dc_next = hp_eff;
                    end
                    i2cm_pkg::PH_TX_HI:
                    begin
                        scl_next = 1'b0; phase_next = i2cm_pkg::PH_TX_TAIL; dc_next = hp_eff;
                    end
                    i2cm_pkg::PH_TX_TAIL:
                    begin
                        bc_next = bc_inc;
                        if (bc_inc >= 4'd8)
                        begin
                            phase_next = i2cm_pkg::PH_IDLE; done = 1'b1;
                        end
                        else
                        begin
                            sda_next = sh_reg[7];
                            sh_next  = {sh_reg[6:0], 1'b0};
                            phase_next = i2cm_pkg::PH_TX_LO; dc_next = hp_eff;
                        end
                    end
                    i2cm_pkg::PH_WA_REL:
                    begin
                        scl_next = 1'b1; phase_next = i2cm_pkg::PH_WA_HI; dc_next = hp_eff;
                    end
                    i2cm_pkg::PH_WA_HI:
                    begin
                        phase_next = i2cm_pkg::PH_WA_POLL;
                    end
                    i2cm_pkg::PH_RD_LO:
                    begin
                        scl_next = 1'b1;
                        sh_next  = {sh_reg[6:0], q_item.sda_in};
                        bc_next  = bc_inc;
                        phase_next = i2cm_pkg::PH_RD_HI; dc_next = hp_eff;
                    end
                    i2cm_pkg::PH_RD_HI:
                    begin
                        scl_next = 1'b0; dc_next = hp_eff;
                        if (bc_reg >= 4'd8)
                        begin
                            rx_next  = sh_reg;
                            sda_next = !ackl_reg;
                            phase_next = i2cm_pkg::PH_AK_LO;
                        end
                        else
                        begin
                            phase_next = i2cm_pkg::PH_RD_LO;
                        end
                    end
                    i2cm_pkg::PH_AK_LO:
                    begin
                        scl_next = 1'b1; phase_next = i2cm_pkg::PH_AK_HI; dc_next = hp_eff;
                    end
                    i2cm_pkg::PH_AK_HI:
                    begin
                        scl_next = 1'b0; phase_next = i2cm_pkg::PH_IDLE; done = 1'b1;
                    end
                    default:
                    begin
                        phase_next = i2cm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            dc_reg        <= 16'd0;
            bc_reg        <= 4'd0;
            sh_reg        <= 8'd0;
            pc_reg        <= 10'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            fail_reg      <= 1'b0;
            ackl_reg      <= 1'b0;
            rx_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                dc_reg    <= dc_next;
                bc_reg    <= bc_next;
                sh_reg    <= sh_next;
                pc_reg    <= pc_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                fail_reg  <= fail_next;
                ackl_reg  <= ackl_next;
                rx_reg    <= rx_next;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {3'd0, fail_next, rx_next, done,
                             (phase_next != i2cm_pkg::PH_IDLE), sda_next, scl_next};
        end
    end

endmodule

`default_nettype wire

[rtl/core/i2c_master_bit_engine.sv]
`default_nettype none

// I2C master bit engine, one bus tick per input word.
//
// Input stream (s_*): each accepted word is one tick of the bus clock. It carries
// the sampled SDA level and, optionally, a command (START, STOP, SEND, WAIT_ACK,
// READ). A command is taken only while the engine is idle; otherwise it is dropped.
// Output stream (m_*): exactly one word per input word, in order, carrying the
// open-drain SCL/SDA levels after that tick, busy, done, the last received byte
// and the acknowledge-timeout flag.
// Config port: cfg_we writes cfg_wdata to register cfg_addr (0 half period in
// ticks, 1 acknowledge timeout in polls). Write only while the engine is idle.
// Throughput: one word per cycle while m_tready stays high. Path: an accepted word
// is first written into the two-entry input queue, then the sequencer advances on it
// and its result word is written into the output register.
// Stall: while m_tready is low the output register holds its word, the sequencer
// stops advancing, and the input queue absorbs up to two more words before
// s_tready drops.
// Reset: bus lines released high, engine idle, queue empty, registers at their
// defaults (half period 4, timeout 250).
module i2c_master_bit_engine (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [3:0]   cfg_addr,
    input  wire [15:0]  cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [15:0]  s_tdata,   // cmd_valid, mode[2:0], tx_byte[7:0], send_ack, sda_in, pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // scl_level, sda_level, busy_res, done_res, rx_byte, ack_fail, pad
);

    logic            q_valid;
    i2cm_pkg::item_t q_item;
    logic            q_pop;

    // Front: decode and queue incoming words.
    i2cm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: advance the bus sequencer and register the result word.
    i2cm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A completing tick never reports busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("done reported together with busy");

    // A full input queue always presents a word to the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("input queue full but empty toward sequencer");

    // The sequencer only pulls words it has room to report.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("word consumed while output stalled");

endmodule

`default_nettype wire

[dv/i2cm_check_pkg.sv]
`timescale 1ns / 100ps

package i2cm_check_pkg;

    import i2cm_pkg::*;

    // Bus status seen on the result stream after one tick.
    typedef struct {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       fail;
    } bus_status_t;

    localparam int REPORT_LIMIT = 10;

    class line_scoreboard;
        logic [HP_W-1:0] half_period;
        logic [TO_W-1:0] ack_limit;
        phase_t          ph;
        logic [15:0]     dly;
        logic [3:0]      bits;
        logic [7:0]      shifter;
        logic [9:0]      polls;
        logic            scl;
        logic            sda;
        logic            fail;
        logic            ack_sel;
        logic [7:0]      rx_hold;
        bus_status_t     expected_status[$];
        int              errors;

        function new();
            half_period = HALF_PERIOD_RST;
            ack_limit   = ACK_TIMEOUT_RST;
            ph          = PH_IDLE;
            dly         = '0;
            bits        = '0;
            shifter     = '0;
            polls       = '0;
            scl         = 1'b1;
            sda         = 1'b1;
            fail        = 1'b0;
            ack_sel     = 1'b0;
            rx_hold     = '0;
            errors      = 0;
        endfunction

        function void set_config(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
            if (idx == CFG_HALF_PERIOD)
                half_period = val;
            else if (idx == CFG_ACK_TIMEOUT)
                ack_limit = val[TO_W-1:0];
        endfunction

        function bit engine_idle();
            return ph == PH_IDLE;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        // Enter a phase and reload the delay; a zero half period counts as one tick.
        function void reload(phase_t next);
            ph  = next;
            dly = (half_period == '0) ? 16'd1 : half_period;
        endfunction

        function void launch(logic [2:0] mode, logic [7:0] tx, logic ack);
            case (mode)
                MODE_START:
                begin
                    sda = 1'b1;
                    scl = 1'b1;
                    reload(PH_ST_A);
                end
                MODE_STOP:
                begin
                    scl = 1'b0;
                    sda = 1'b0;
                    reload(PH_SP_A);
                end
                MODE_SEND:
                begin
                    scl     = 1'b0;
                    bits    = '0;
                    sda     = tx[7];
                    shifter = {tx[6:0], 1'b0};
                    reload(PH_TX_LO);
                end
                MODE_WAIT:
                begin
                    sda   = 1'b1;
                    fail  = 1'b0;
                    polls = '0;
                    reload(PH_WA_REL);
                end
                MODE_READ:
                begin
                    sda     = 1'b1;
                    scl     = 1'b0;
                    shifter = '0;
                    bits    = '0;
                    ack_sel = ack;
                    reload(PH_RD_LO);
                end
                default:
                begin
                end
            endcase
        endfunction

        // Move on once the delay has run out; report completion of a command.
        function logic step_phase(logic sda_in);
            case (ph)
                PH_ST_A:
                begin
                    sda = 1'b0;
                    reload(PH_ST_B);
                end
                PH_ST_B:
                begin
                    scl = 1'b0;
                    ph  = PH_IDLE;
                    return 1'b1;
                end
                PH_SP_A:
                begin
                    scl = 1'b1;
                    reload(PH_SP_B);
                end
                PH_SP_B:
                begin
                    sda = 1'b1;
                    reload(PH_SP_C);
                end
                PH_SP_C:
                begin
                    ph = PH_IDLE;
                    return 1'b1;
                end
                PH_TX_LO:
                begin
                    scl = 1'b1;
                    reload(PH_TX_HI);
                end
                PH_TX_HI:
                begin
                    scl = 1'b0;
                    reload(PH_TX_TAIL);
                end
                PH_TX_TAIL:
                begin
                    bits = bits + 4'd1;
                    if (bits >= 4'd8)
                    begin
                        ph = PH_IDLE;
                        return 1'b1;
                    end
                    sda     = shifter[7];
                    shifter = {shifter[6:0], 1'b0};
                    reload(PH_TX_LO);
                end
                PH_WA_REL:
                begin
                    scl = 1'b1;
                    reload(PH_WA_HI);
                end
                PH_WA_HI:
                    ph = PH_WA_POLL;
                PH_RD_LO:
                begin
                    scl     = 1'b1;
                    shifter = {shifter[6:0], sda_in};
                    bits    = bits + 4'd1;
                    reload(PH_RD_HI);
                end
                PH_RD_HI:
                begin
                    scl = 1'b0;
                    if (bits >= 4'd8)
                    begin
                        rx_hold = shifter;
                        sda     = ~ack_sel;
                        reload(PH_AK_LO);
                    end
                    else
                        reload(PH_RD_LO);
                end
                PH_AK_LO:
                begin
                    scl = 1'b1;
                    reload(PH_AK_HI);
                end
                PH_AK_HI:
                begin
                    scl = 1'b0;
                    ph  = PH_IDLE;
                    return 1'b1;
                end
                default:
                    ph = PH_IDLE;
            endcase
            return 1'b0;
        endfunction

        // Advance the predicted engine by one accepted tick and queue its status.
        function void note_tick(logic [15:0] word);
            logic        valid;
            logic [2:0]  mode;
            logic [7:0]  tx;
            logic        ack;
            logic        sda_in;
            logic        done;
            bus_status_t st;
            valid  = word[0];
            mode   = word[3:1];
            tx     = word[11:4];
            ack    = word[12];
            sda_in = word[13];
            done   = 1'b0;
            if (ph == PH_IDLE)
            begin
                if (valid)
                    launch(mode, tx, ack);
            end
            else if (ph == PH_WA_POLL)
            begin
                if (!sda_in)
                begin
                    scl  = 1'b0;
                    ph   = PH_IDLE;
                    done = 1'b1;
                end
                else if (polls >= ack_limit)
                begin
                    fail = 1'b1;
                    scl  = 1'b0;
                    sda  = 1'b0;
                    reload(PH_SP_A);
                end
                else
                    polls = polls + 10'd1;
            end
            else
            begin
                if (dly > 0)
                    dly = dly - 16'd1;
                if (dly == 0)
                    done = step_phase(sda_in);
            end
            st.scl  = scl;
            st.sda  = sda;
            st.busy = (ph != PH_IDLE);
            st.done = done;
            st.rx   = rx_hold;
            st.fail = fail;
            expected_status.push_back(st);
        endfunction

        function void check_lines(logic [15:0] word);
            bus_status_t want;
            bus_status_t got;
            got.scl  = word[0];
            got.sda  = word[1];
            got.busy = word[2];
            got.done = word[3];
            got.rx   = word[11:4];
            got.fail = word[12];
            if (expected_status.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected status word %04h", $realtime, word);
                return;
            end
            want = expected_status.pop_front();
            if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
                got.done !== want.done || got.rx !== want.rx || got.fail !== want.fail)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"%0t: mismatch exp scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ",
                              "fail=%0b, got scl=%0b sda=%0b busy=%0b done=%0b rx=%02h fail=%0b"},
                             $realtime, want.scl, want.sda, want.busy, want.done, want.rx,
                             want.fail, got.scl, got.sda, got.busy, got.done, got.rx, got.fail);
            end
        endfunction
    endclass

endpackage

[dv/i2c_master_bit_engine_test.sv]
`timescale 1ns / 100ps

module i2c_master_bit_engine_test;

    import i2cm_pkg::*;
    import i2cm_check_pkg::*;

    // Cycles with no word moving on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Cycles to let pass after the last status word: two-stage pipeline plus margin.
    localparam int DRAIN_CYCLES   = 4;
    // Length of the deliberate receiver hold-off that backs up the input side.
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_WORDS    = 165;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    line_scoreboard board = new();

    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    i2c_master_bit_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // cmd_valid, mode[2:0], tx_byte[7:0], send_ack, sda_in, pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // scl_level, sda_level, busy_res, done_res, rx_byte, ack_fail, pad
    );

    always #1 clk = ~clk;

    // Receiver: stall at the phase's rate; on request, hold off for a long stretch
    // so the input queue fills and s_tready drops while the sender keeps offering.
    always @(negedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Check every status word taken by the receiver against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_lines(m_tdata);
    end

    // Watchdog: count cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("i2c_master_bit_engine_test: FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] pack_item(logic valid, logic [2:0] mode, logic [7:0] tx,
                                              logic ack, logic sda_in);
        return {2'b00, sda_in, ack, tx, mode, valid};
    endfunction

    // SDA level for one tick: high with the given percentage.
    function automatic logic pick_sda(int one_pct);
        return ($urandom_range(99) < one_pct);
    endfunction

    // Offer one word from the falling edge, idle first at the sender's gap rate,
    // then hold it until the rising edge that takes it and feed the predictor.
    task automatic drive_word(input logic [15:0] word);
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_tick(word);
    endtask

    // Tick the bus with no command until the predicted engine is idle again.
    task automatic finish_cmd(input int sda_pct);
        while (!board.engine_idle())
            drive_word(pack_item(1'b0, 3'($urandom), 8'($urandom), 1'($urandom),
                                 pick_sda(sda_pct)));
    endtask

    task automatic run_cmd(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                           input int sda_pct);
        drive_word(pack_item(1'b1, mode, tx, ack, pick_sda(sda_pct)));
        finish_cmd(sda_pct);
    endtask

    // Bring the engine to idle, drop valid, wait for every status word and let
    // the pipeline empty before any register write.
    task automatic quiesce();
        finish_cmd(50);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_config(idx, val);
    endtask

    // Random traffic: mostly commands issued while idle with a per-command SDA
    // bias, so that acks, timeouts and read patterns all occur; a few commands
    // while busy and a few unused modes as noise.
    task automatic random_phase(input int gap_pct, input int stall_pct, input bit with_hold);
        int         sda_pct;
        logic       valid;
        logic [2:0] mode;
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        sda_pct      = 50;
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            if (with_hold && n == PHASE_WORDS / 3)
                hold_requests++;
            if (board.engine_idle())
            begin
                valid = ($urandom_range(9) < 6);
                if ($urandom_range(9) == 0)
                    mode = 3'($urandom_range(7, MODE_READ + 1));
                else
                    mode = 3'($urandom_range(MODE_READ, MODE_START));
                if (valid)
                begin
                    case ($urandom_range(3))
                        0: sda_pct = 0;
                        1: sda_pct = 50;
                        2: sda_pct = 90;
                        default: sda_pct = 100;
                    endcase
                end
            end
            else
            begin
                valid = ($urandom_range(24) == 0);
                mode  = 3'($urandom_range(7));
            end
            drive_word(pack_item(valid, mode, 8'($urandom), 1'($urandom), pick_sda(sda_pct)));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset defaults (half period 4, timeout 250).
        run_cmd(MODE_START, 8'h00, 1'b0, 50);
        run_cmd(MODE_SEND, 8'hA5, 1'b0, 50);
        run_cmd(MODE_WAIT, 8'h00, 1'b0, 0);
        run_cmd(MODE_READ, 8'h00, 1'b1, 100);
        run_cmd(MODE_STOP, 8'h00, 1'b0, 50);
        quiesce();

        // Shortest legal half period: byte extremes, ACK and NACK after reads.
        write_reg(CFG_HALF_PERIOD, 16'd1);
        run_cmd(MODE_SEND, 8'hFF, 1'b0, 50);
        run_cmd(MODE_SEND, 8'h00, 1'b1, 50);
        run_cmd(MODE_READ, 8'hFF, 1'b0, 0);
        run_cmd(MODE_READ, 8'h00, 1'b1, 50);
        // Unused modes: no bus activity, no done.
        for (int m = MODE_READ + 1; m <= 7; m++)
            drive_word(pack_item(1'b1, 3'(m), 8'($urandom), 1'($urandom), 1'b1));
        // Command while busy: the STOP offered mid-byte must be dropped.
        drive_word(pack_item(1'b1, MODE_SEND, 8'h3C, 1'b0, 1'b1));
        drive_word(pack_item(1'b1, MODE_STOP, 8'h00, 1'b0, 1'b1));
        finish_cmd(50);
        quiesce();

        // Zero half period acts as one tick; zero timeout fails on the first high poll.
        write_reg(CFG_HALF_PERIOD, 16'd0);
        write_reg(CFG_ACK_TIMEOUT, 16'd0);
        run_cmd(MODE_WAIT, 8'h00, 1'b0, 100);
        run_cmd(MODE_WAIT, 8'h00, 1'b0, 0);
        run_cmd(MODE_START, 8'h00, 1'b0, 50);
        quiesce();

        // Longest timeout, acknowledged on the first poll.
        write_reg(CFG_HALF_PERIOD, 16'd1);
        write_reg(CFG_ACK_TIMEOUT, 16'd1023);
        run_cmd(MODE_WAIT, 8'h00, 1'b0, 0);
        quiesce();

        // Out-of-range register indexes are ignored.
        write_reg(4'd2, 16'hFFFF);
        write_reg(4'd15, 16'h0000);
        run_cmd(MODE_SEND, 8'h81, 1'b0, 50);
        quiesce();

        // Random phases: full rate with a long receiver hold-off, sender idling,
        // receiver stalling, both idling.
        write_reg(CFG_HALF_PERIOD, 16'd1);
        write_reg(CFG_ACK_TIMEOUT, 16'd3);
        random_phase(0, 0, 1'b1);
        quiesce();

        write_reg(CFG_HALF_PERIOD, 16'd2);
        write_reg(CFG_ACK_TIMEOUT, 16'($urandom_range(12)));
        random_phase(73, 0, 1'b0);
        quiesce();

        write_reg(CFG_HALF_PERIOD, 16'($urandom_range(3, 1)));
        write_reg(CFG_ACK_TIMEOUT, 16'($urandom_range(8, 1)));
        random_phase(0, 73, 1'b0);
        quiesce();

        write_reg(CFG_HALF_PERIOD, 16'($urandom_range(2)));
        write_reg(CFG_ACK_TIMEOUT, 16'($urandom_range(5)));
        random_phase(34, 34, 1'b0);
        quiesce();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("i2c_master_bit_engine_test: PASS");
        else
            $display("i2c_master_bit_engine_test: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_back.sv
rtl/core/i2c_master_bit_engine.sv
dv/i2cm_check_pkg.sv
dv/i2c_master_bit_engine_test.sv
